// ===== src/dfr_pkg.sv =====
// Shared types and constants for the delimited frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package dfr_pkg;

    localparam int unsigned FRAME_LEN_DEF = 20;
    localparam int unsigned WORD_BYTES    = 4;
    localparam int unsigned WORD_COUNT    = 4;
    localparam int unsigned PAYLOAD_BYTES = WORD_BYTES * WORD_COUNT;

    localparam logic [7:0] START_BYTE = 8'h73;  // 's'
    localparam logic [7:0] END_BYTE   = 8'h65;  // 'e'

    localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
    localparam logic [31:0] FRAC_MASK = 32'h007F_FFFF;

    typedef struct packed {
        logic [31:0] yaw_bits;
        logic [31:0] pitch_bits;
        logic [31:0] yaw_rate_bits;
        logic [31:0] pitch_rate_bits;
        logic [7:0]  status_flags;
        logic        angle_invalid;
        logic [15:0] frames_accepted;
    } t_result;

    function automatic logic is_nan(input logic [31:0] w);
        is_nan = ((w & EXP_MASK) == EXP_MASK) && ((w & FRAC_MASK) != 32'h0);
    endfunction

endpackage

// ===== src/delimited_frame_receiver_core.sv =====
// Top level of the delimited frame receiver: framing, checksum and result register.
// Depends on dfr_pkg and dfr_result_form.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Payload
// rx        in   i_rx_valid / o_rx_ready    i_rx_byte
// out       out  o_out_valid / i_out_ready  o_yaw_bits .. o_frames_accepted
//
// One byte beat per cycle while o_rx_ready is high. The framing state (position, running
// sum) updates on the accepting edge; the end byte completes the frame and the
// result lands in the output register on that same edge.
// Reset (synchronous, active low) clears framing state, kept flags, the frame
// count and the output valid; stored frame bytes are not cleared.
// o_rx_ready drops only when the next byte is the end position and the output
// register still holds an untaken result; every other byte is taken regardless.

module delimited_frame_receiver_core #(
    parameter int unsigned FRAME_LEN = dfr_pkg::FRAME_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_yaw_bits,
    output logic [31:0] o_pitch_bits,
    output logic [31:0] o_yaw_rate_bits,
    output logic [31:0] o_pitch_rate_bits,
    output logic [7:0]  o_status_flags,
    output logic        o_angle_invalid,
    output logic [15:0] o_frames_accepted
);
    import dfr_pkg::*;

    localparam int unsigned POS_W   = $clog2(FRAME_LEN);
    localparam int unsigned LAST    = FRAME_LEN - 1;   // end byte position
    localparam int unsigned CSUM    = FRAME_LEN - 2;   // checksum byte
    localparam int unsigned FLAGP   = FRAME_LEN - 3;   // flag byte, last summed

    // framing state
    logic             r_in_frame, n_in_frame;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_last_flags, n_last_flags;
    logic [15:0]      r_count, n_count;

    // stored bytes, positions 1 .. checksum; byte 0 is always 's'
    logic [7:0]       r_bytes [1:CSUM];

    // output register
    logic             r_out_valid, n_out_valid;
    t_result          r_out;

    logic             rx_beat, at_last, frame_ok, emit;
    logic [8*PAYLOAD_BYTES-1:0] payload;
    t_result          formed;

    assign at_last    = r_in_frame && (r_pos == POS_W'(LAST));
    assign o_rx_ready = !(at_last && r_out_valid && !i_out_ready);
    assign rx_beat    = i_rx_valid && o_rx_ready;
    assign frame_ok   = (i_rx_byte == END_BYTE) && (r_sum == r_bytes[CSUM]);
    assign emit       = rx_beat && at_last && frame_ok;

    always_comb begin
        for (int k = 1; k <= PAYLOAD_BYTES; k++) begin
            payload[8*(k-1) +: 8] = r_bytes[k];
        end
    end

    dfr_result_form u_form (
        .i_payload    (payload),
        .i_flag_byte  (r_bytes[FLAGP]),
        .i_last_flags (r_last_flags),
        .i_count      (r_count + 16'd1),
        .o_result     (formed)
    );

    always_comb begin
        n_in_frame   = r_in_frame;
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_last_flags = r_last_flags;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        if (rx_beat) begin
            if (!r_in_frame) begin
                if (i_rx_byte == START_BYTE) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_W'(1);
                    n_sum      = 8'd0;
                end
            end else if (at_last) begin
                // end of frame either way: back to hunting for 's'
                n_in_frame = 1'b0;
                n_pos      = '0;
                n_sum      = 8'd0;
                if (frame_ok) begin
                    n_count      = formed.frames_accepted;
                    n_last_flags = formed.status_flags;
                    n_out_valid  = 1'b1;
                end
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (r_pos <= POS_W'(FLAGP)) begin
                    n_sum = r_sum + i_rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_pos        <= '0;
            r_sum        <= 8'd0;
            r_last_flags <= 8'd0;
            r_count      <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_pos        <= n_pos;
            r_sum        <= n_sum;
            r_last_flags <= n_last_flags;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    // byte store: position decode, only while inside a frame
    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= CSUM; k++) begin
            if (rx_beat && r_in_frame && (r_pos == POS_W'(k))) begin
                r_bytes[k] <= i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= formed;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_yaw_bits        = r_out.yaw_bits;
    assign o_pitch_bits      = r_out.pitch_bits;
    assign o_yaw_rate_bits   = r_out.yaw_rate_bits;
    assign o_pitch_rate_bits = r_out.pitch_rate_bits;
    assign o_status_flags    = r_out.status_flags;
    assign o_angle_invalid   = r_out.angle_invalid;
    assign o_frames_accepted = r_out.frames_accepted;

endmodule

// ===== src/dfr_result_form.sv =====
// Builds one result beat from the stored payload bytes of a completed frame.
// Depends on dfr_pkg (t_result, is_nan).
`timescale 1ns / 1ps

module dfr_result_form (
    input  logic [8*dfr_pkg::PAYLOAD_BYTES-1:0] i_payload,
    input  logic [7:0]                          i_flag_byte,
    input  logic [7:0]                          i_last_flags,
    input  logic [15:0]                         i_count,
    output dfr_pkg::t_result                    o_result
);
    import dfr_pkg::*;

    logic bad;

    // payload byte 0 is frame byte 1, least significant first
    always_comb begin
        o_result.yaw_bits        = i_payload[31:0];
        o_result.pitch_bits      = i_payload[63:32];
        o_result.yaw_rate_bits   = i_payload[95:64];
        o_result.pitch_rate_bits = i_payload[127:96];
        bad = is_nan(i_payload[31:0]) || is_nan(i_payload[63:32]);
        o_result.angle_invalid   = bad;
        o_result.status_flags    = bad ? i_last_flags : i_flag_byte;
        o_result.frames_accepted = i_count;
    end

endmodule
